>>> design/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the ring message queue with urgent insert.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int MSG_WIDTH_DEF = 32;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam int OP_W   = 2;
    localparam int FILL_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_SEND   = 2'd0,
        OP_URGENT = 2'd1,
        OP_RECV   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [FILL_W-1:0] {
        FILL_EMPTY   = 2'd0,
        FILL_PARTIAL = 2'd1,
        FILL_FULL    = 2'd2
    } fill_t;

endpackage

>>> design/rmq_if.sv
// ----------------------------------------------------------------------------
// rmq_in_if / rmq_out_if
// Valid/ready channels for queue operations and their results.
// ----------------------------------------------------------------------------
interface rmq_in_if #(
    parameter int MSG_WIDTH = rmq_pkg::MSG_WIDTH_DEF
);
    logic                      valid;
    logic                      ready;
    logic [rmq_pkg::OP_W-1:0]  opcode;
    logic [MSG_WIDTH-1:0]      message_in;

    modport source (output valid, output opcode, output message_in, input ready);
    modport sink   (input valid, input opcode, input message_in, output ready);
endinterface

interface rmq_out_if #(
    parameter int MSG_WIDTH = rmq_pkg::MSG_WIDTH_DEF,
    parameter int CNT_W     = 5
);
    logic                        valid;
    logic                        ready;
    logic                        success;
    logic                        error_code;
    logic [MSG_WIDTH-1:0]        message_out;
    logic [rmq_pkg::FILL_W-1:0]  fill_state;
    logic [CNT_W-1:0]            entries;

    modport source (output valid, output success, output error_code, output message_out,
                    output fill_state, output entries, input ready);
    modport sink   (input valid, input success, input error_code, input message_out,
                    input fill_state, input entries, output ready);
endinterface

>>> design/ring_message_queue_with_urgent_insert.sv
// ----------------------------------------------------------------------------
// ring_message_queue_with_urgent_insert
// Ring-buffer message queue with a programmable capacity and front insert.
// ----------------------------------------------------------------------------
// usage
//   req carries one operation word: opcode (send, urgent send, receive,
//   clear) and message_in. rsp returns one result word per operation:
//   success, error_code, message_out, fill_state and entries.
//   cfg_we/cfg_wdata write the capacity register and empty the queue; the user
//   must issue a write only while idle, which the block does not enforce.
// throughput
//   one operation per cycle while rsp is not held; each result appears in
//   the rsp register in the cycle after its word is taken. the pointer
//   update and the single slot read or write happen when the word is taken,
//   the slot store read data being the registered message_out.
// reset
//   rst_n clears the pointers, count and status and sets capacity to 16;
//   the slot store is not cleared, only written slots are ever read.
// stall
//   while rsp is held by the receiver, req.ready stays low and the result
//   word holds; req.ready is high whenever the result register is free or
//   being taken in the same cycle.
// ----------------------------------------------------------------------------
module ring_message_queue_with_urgent_insert #(
    parameter int DEPTH     = rmq_pkg::DEPTH_DEF,
    parameter int MSG_WIDTH = rmq_pkg::MSG_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [rmq_pkg::CAP_W-1:0] cfg_wdata,
    rmq_in_if.sink                    req,
    rmq_out_if.source                 rsp
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] inc;
        inc = CNT_W'(p) + CNT_W'(1);
        return (inc >= cap) ? '0 : PTR_W'(inc);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] cap);
        logic [PTR_W-1:0] dec;
        dec = p - PTR_W'(1);
        return (p == '0 || CNT_W'(p) > cap) ? PTR_W'(cap - CNT_W'(1)) : dec;
    endfunction

    logic [MSG_WIDTH-1:0]       mem [DEPTH];

    logic [rmq_pkg::CAP_W-1:0]  cap_reg;
    logic [PTR_W-1:0]           wp_reg, wp_next;
    logic [PTR_W-1:0]           rp_reg, rp_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    rmq_pkg::fill_t             status_reg, status_next;

    logic                       out_valid_reg;
    logic                       success_reg, success_next;
    logic                       error_reg, error_next;
    logic [MSG_WIDTH-1:0]       rd_data_reg;

    logic [CNT_W-1:0]           cap_use;
    logic                       in_fire;
    logic                       wr_en;
    logic [PTR_W-1:0]           wr_addr;
    logic                       rd_en;
    rmq_pkg::op_t               op;

    assign in_fire   = req.valid && req.ready;
    assign req.ready = !out_valid_reg || rsp.ready;
    assign op        = rmq_pkg::op_t'(req.opcode);

    // capacity clamped to 1..DEPTH
    always_comb
    begin
        priority if (cap_reg == '0)
        begin
            cap_use = CNT_W'(1);
        end
        else if (32'(cap_reg) > 32'(DEPTH))
        begin
            cap_use = CNT_W'(DEPTH);
        end
        else
        begin
            cap_use = CNT_W'(cap_reg);
        end
    end

    always_comb
    begin
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        success_next = 1'b1;
        error_next   = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = wp_reg;
        rd_en        = 1'b0;
        unique case (op)
            rmq_pkg::OP_SEND, rmq_pkg::OP_URGENT:
            begin
                if (status_reg == rmq_pkg::FILL_FULL)
                begin
                    success_next = 1'b0;
                    error_next   = 1'b1;
                end
                else
                begin
                    if (op == rmq_pkg::OP_SEND)
                    begin
                        wr_addr = wp_reg;
                        wp_next = ptr_next(wp_reg, cap_use);
                    end
                    else
                    begin
                        rp_next = ptr_prev(rp_reg, cap_use);
                        wr_addr = rp_next;
                    end
                    wr_en       = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    status_next = (rp_next == wp_next) ? rmq_pkg::FILL_FULL
                                                       : rmq_pkg::FILL_PARTIAL;
                end
            end
            rmq_pkg::OP_RECV:
            begin
                if (status_reg == rmq_pkg::FILL_EMPTY)
                begin
                    success_next = 1'b0;
                    error_next   = 1'b1;
                end
                else
                begin
                    rd_en = 1'b1;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    rp_next     = ptr_next(rp_reg, cap_use);
                    status_next = (rp_next == wp_reg) ? rmq_pkg::FILL_EMPTY
                                                      : rmq_pkg::FILL_PARTIAL;
                end
            end
            rmq_pkg::OP_CLEAR:
            begin
                wp_next     = '0;
                rp_next     = '0;
                count_next  = '0;
                status_next = rmq_pkg::FILL_EMPTY;
            end
            default:
            begin
                success_next = 1'b1;
            end
        endcase
    end

    // queue state and capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= rmq_pkg::CAP_RESET;
            wp_reg     <= '0;
            rp_reg     <= '0;
            count_reg  <= '0;
            status_reg <= rmq_pkg::FILL_EMPTY;
        end
        else if (cfg_we)
        begin
            cap_reg    <= cfg_wdata;
            wp_reg     <= '0;
            rp_reg     <= '0;
            count_reg  <= '0;
            status_reg <= rmq_pkg::FILL_EMPTY;
        end
        else if (in_fire)
        begin
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // slot store, read data registered as the result word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (wr_en)
            begin
                mem[wr_addr] <= req.message_in;
            end
            rd_data_reg <= rd_en ? mem[rp_reg] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            success_reg <= success_next;
            error_reg   <= error_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.success     = success_reg;
    assign rsp.error_code  = error_reg;
    assign rsp.message_out = rd_data_reg;
    assign rsp.fill_state  = status_reg;
    assign rsp.entries     = count_reg;

    // full queue holds exactly the capacity in use
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg == rmq_pkg::FILL_FULL) |-> (count_reg == cap_use))
        else $error("full status with wrong message count");

    // empty queue holds nothing and its pointers meet
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg == rmq_pkg::FILL_EMPTY) |-> (count_reg == '0 && rp_reg == wp_reg))
        else $error("empty status with messages held");

    // pointers stay inside the capacity in use
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(wp_reg) < cap_use) && (CNT_W'(rp_reg) < cap_use))
        else $error("pointer beyond capacity");

    // a failed operation always reports an error and leaves the count alone
    a_fail_error: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !cfg_we && !success_next) |=> (error_reg && $stable(count_reg)))
        else $error("failed operation without error or with state change");

endmodule

>>> tb/rmq_result_checker.sv
// ----------------------------------------------------------------------------
// rmq_result_checker
// Watches the request and result channels of the ring message queue. Each
// accepted request word is run through a cycle-free model of the queue,
// which keeps its own pointers, count, status and capacity, and the predicted
// result is queued. Each accepted result word is compared field by field with
// the oldest prediction. Capacity writes are tracked from the config port.
// ----------------------------------------------------------------------------
module rmq_result_checker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [rmq_pkg::CAP_W-1:0] cfg_wdata,
    rmq_in_if                         req,
    rmq_out_if                        rsp,
    output int                        bad_results,
    output int                        pending_results
);

    localparam int DEPTH = rmq_pkg::DEPTH_DEF;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int MSG_W = rmq_pkg::MSG_WIDTH_DEF;
    localparam int CAP_W = rmq_pkg::CAP_W;

    typedef struct {
        logic                success;
        logic                error_code;
        logic [MSG_W-1:0]    message_out;
        rmq_pkg::fill_t      fill_state;
        logic [CAP_W-1:0]    entries;
    } queue_result_t;

    logic [MSG_W-1:0]         slots [DEPTH];
    logic [CAP_W-1:0]         capacity;
    logic [PTR_W-1:0]         wr_ptr;
    logic [PTR_W-1:0]         rd_ptr;
    logic [CAP_W-1:0]         held;
    rmq_pkg::fill_t           fill;
    queue_result_t            awaited_results [$];
    int                       errors_seen = 0;

    function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p,
                                                   logic [CAP_W-1:0] lim);
        logic [CAP_W-1:0] nxt;
        nxt = CAP_W'(p) + 1'b1;
        return (nxt >= lim) ? '0 : nxt[PTR_W-1:0];
    endfunction

    function automatic void empty_queue();
        wr_ptr = '0;
        rd_ptr = '0;
        held   = '0;
        fill   = rmq_pkg::FILL_EMPTY;
    endfunction

    function automatic queue_result_t apply_queue_op(rmq_pkg::op_t op,
                                                     logic [MSG_W-1:0] word);
        queue_result_t    r;
        logic [CAP_W-1:0] lim;
        lim = (capacity == '0) ? CAP_W'(1) : (capacity > DEPTH) ? CAP_W'(DEPTH) : capacity;
        r.success     = 1'b1;
        r.error_code  = 1'b0;
        r.message_out = '0;
        case (op)
            rmq_pkg::OP_SEND, rmq_pkg::OP_URGENT:
            begin
                if (fill == rmq_pkg::FILL_FULL)
                begin
                    r.success    = 1'b0;
                    r.error_code = 1'b1;
                end
                else
                begin
                    if (op == rmq_pkg::OP_SEND)
                    begin
                        slots[wr_ptr] = word;
                        wr_ptr = ring_next(wr_ptr, lim);
                    end
                    else
                    begin
                        // urgent word goes in just ahead of the read pointer
                        if (rd_ptr == '0 || CAP_W'(rd_ptr) > lim)
                            rd_ptr = PTR_W'(lim - 1'b1);
                        else
                            rd_ptr = rd_ptr - 1'b1;
                        slots[rd_ptr] = word;
                    end
                    held = held + 1'b1;
                    fill = (rd_ptr == wr_ptr) ? rmq_pkg::FILL_FULL : rmq_pkg::FILL_PARTIAL;
                end
            end
            rmq_pkg::OP_RECV:
            begin
                if (fill == rmq_pkg::FILL_EMPTY)
                begin
                    r.success    = 1'b0;
                    r.error_code = 1'b1;
                end
                else
                begin
                    r.message_out = slots[rd_ptr];
                    if (held != '0)
                        held = held - 1'b1;
                    rd_ptr = ring_next(rd_ptr, lim);
                    fill   = (rd_ptr == wr_ptr) ? rmq_pkg::FILL_EMPTY
                                                : rmq_pkg::FILL_PARTIAL;
                end
            end
            default:
                empty_queue();
        endcase
        r.fill_state = fill;
        r.entries    = held;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t seen;
        queue_result_t want;
        if (!rst_n)
        begin
            capacity = rmq_pkg::CAP_RESET;
            empty_queue();
            awaited_results.delete();
        end
        else
        begin
            // result words are taken before new requests
            if (rsp.valid && rsp.ready)
            begin
                seen.success     = rsp.success;
                seen.error_code  = rsp.error_code;
                seen.message_out = rsp.message_out;
                seen.fill_state  = rmq_pkg::fill_t'(rsp.fill_state);
                seen.entries     = rsp.entries;
                if (awaited_results.size() == 0)
                begin
                    errors_seen++;
                    if (errors_seen <= 10)
                        $display("result word with none awaited: ",
                                 "ok=%0b err=%0b msg=%08h fill=%0d n=%0d",
                                 seen.success, seen.error_code, seen.message_out,
                                 seen.fill_state, seen.entries);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (seen.success !== want.success || seen.error_code !== want.error_code ||
                        seen.message_out !== want.message_out ||
                        seen.fill_state !== want.fill_state || seen.entries !== want.entries)
                    begin
                        errors_seen++;
                        if (errors_seen <= 10)
                            $display("wrong result word: ",
                                     "expected ok=%0b err=%0b msg=%08h fill=%0d n=%0d, ",
                                     want.success, want.error_code, want.message_out,
                                     want.fill_state, want.entries,
                                     "got ok=%0b err=%0b msg=%08h fill=%0d n=%0d",
                                     seen.success, seen.error_code, seen.message_out,
                                     seen.fill_state, seen.entries);
                    end
                end
            end
            if (cfg_we)
            begin
                capacity = cfg_wdata;
                empty_queue();
            end
            if (req.valid && req.ready)
                awaited_results.push_back(apply_queue_op(rmq_pkg::op_t'(req.opcode),
                                                         req.message_in));
        end
        pending_results <= awaited_results.size();
        bad_results     <= errors_seen;
    end

endmodule

>>> tb/ring_message_queue_with_urgent_insert_test.sv
// ----------------------------------------------------------------------------
// ring_message_queue_with_urgent_insert_test
// Drives the queue with a short directed run (empty and full errors, urgent
// insert wrapping at slot zero, clears, a zero capacity) and then with
// phases of random operations at a range of capacities, each phase made
// of stretches biased towards filling, draining or a mix. Both channels
// stall at random. Checking is done by rmq_result_checker beside the block.
// ----------------------------------------------------------------------------
module ring_message_queue_with_urgent_insert_test;

    logic                      clk    = 1'b0;
    logic                      rst_n  = 1'b0;
    logic                      steady = 1'b0;
    logic                      cfg_we;
    logic [rmq_pkg::CAP_W-1:0] cfg_wdata;
    int                        bad_results;
    int                        pending_results;
    int                        random_count = 0;

    rmq_in_if  req_ch ();
    rmq_out_if rsp_ch ();

    ring_message_queue_with_urgent_insert i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    rmq_result_checker i_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .bad_results     (bad_results),
        .pending_results (pending_results)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        rsp_ch.ready <= steady || ($urandom_range(99) >= 23);

    initial
    begin
        #400000;
        $display("ring_message_queue_with_urgent_insert: mismatch");
        $finish;
    end

    task automatic push_word(input rmq_pkg::op_t op,
                             input logic [rmq_pkg::MSG_WIDTH_DEF-1:0] word);
        if (!steady && $urandom_range(99) < 23)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.message_in <= word;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [rmq_pkg::CAP_W-1:0] cap);
        wait_for_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [rmq_pkg::CAP_W-1:0] cap, input int count);
        int           mode;
        int           roll;
        int           send_lim;
        int           urgent_lim;
        int           recv_lim;
        rmq_pkg::op_t op;
        write_capacity(cap);
        mode = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                mode = $urandom_range(2);
            // fill-heavy, drain-heavy or mixed stretches
            case (mode)
                0:       begin send_lim = 50; urgent_lim = 75; recv_lim = 97; end
                1:       begin send_lim = 15; urgent_lim = 28; recv_lim = 97; end
                default: begin send_lim = 30; urgent_lim = 48; recv_lim = 95; end
            endcase
            roll = $urandom_range(99);
            if (roll < send_lim)
                op = rmq_pkg::OP_SEND;
            else if (roll < urgent_lim)
                op = rmq_pkg::OP_URGENT;
            else if (roll < recv_lim)
                op = rmq_pkg::OP_RECV;
            else
                op = rmq_pkg::OP_CLEAR;
            steady <= (random_count >= 300 && random_count < 480);
            random_count++;
            push_word(op, $urandom);
        end
    endtask

    initial
    begin
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= rmq_pkg::OP_SEND;
        req_ch.message_in <= '0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= rmq_pkg::CAP_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // capacity from reset
        push_word(rmq_pkg::OP_RECV,   32'h0000_0000);
        push_word(rmq_pkg::OP_SEND,   32'h0000_0000);
        push_word(rmq_pkg::OP_SEND,   32'hFFFF_FFFF);
        push_word(rmq_pkg::OP_URGENT, 32'h8000_0001);
        push_word(rmq_pkg::OP_RECV,   32'h5555_5555);
        push_word(rmq_pkg::OP_RECV,   32'h0000_0000);
        push_word(rmq_pkg::OP_RECV,   32'h0000_0000);
        push_word(rmq_pkg::OP_RECV,   32'h0000_0000);
        push_word(rmq_pkg::OP_SEND,   32'h1234_5678);
        push_word(rmq_pkg::OP_CLEAR,  32'hAAAA_AAAA);
        push_word(rmq_pkg::OP_CLEAR,  32'h0000_0000);
        push_word(rmq_pkg::OP_RECV,   32'h0000_0000);

        // two slots: urgent wrap, full on both kinds of send
        write_capacity(5'd2);
        push_word(rmq_pkg::OP_URGENT, 32'hA5A5_A5A5);
        push_word(rmq_pkg::OP_SEND,   32'h5A5A_5A5A);
        push_word(rmq_pkg::OP_SEND,   32'hDEAD_BEEF);
        push_word(rmq_pkg::OP_URGENT, 32'hCAFE_F00D);
        push_word(rmq_pkg::OP_RECV,   32'h0000_0000);
        push_word(rmq_pkg::OP_RECV,   32'h0000_0000);
        push_word(rmq_pkg::OP_RECV,   32'h0000_0000);

        // zero capacity behaves as one slot
        write_capacity(5'd0);
        push_word(rmq_pkg::OP_SEND,   32'h0F0F_0F0F);
        push_word(rmq_pkg::OP_URGENT, 32'hF0F0_F0F0);
        push_word(rmq_pkg::OP_CLEAR,  32'h0000_0000);
        push_word(rmq_pkg::OP_RECV,   32'h0000_0000);

        run_phase(5'd16, 120);
        run_phase(5'd3,  120);
        run_phase(5'd31, 120);
        run_phase(5'd1,  120);
        run_phase(5'd7,  120);
        run_phase(5'd17, 120);
        run_phase(5'd0,  120);
        run_phase(5'd2,  120);
        run_phase(rmq_pkg::CAP_W'($urandom_range(1, 16)), 120);

        wait_for_drain();
        if (bad_results == 0 && pending_results == 0)
            $display("ring_message_queue_with_urgent_insert: match");
        else
            $display("ring_message_queue_with_urgent_insert: mismatch");
        $finish;
    end

endmodule
